[rtl/ptb_pkg.sv]
package ptb_pkg;

  localparam int NUM_TIMERS_DEF  = 16;
  localparam int PERIOD_BITS_DEF = 24;

  localparam int ACT_W  = 3;
  localparam int ID_W   = 4;
  localparam int LEN_W  = 24;
  localparam int PEND_W = 32;

  localparam logic [ACT_W-1:0] ACT_START = 3'd0;
  localparam logic [ACT_W-1:0] ACT_STOP  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TICK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_QEXP  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QRUN  = 3'd4;

endpackage

[rtl/ptb_ram.sv]
module ptb_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/periodic_timer_bank.sv]
// Bank of NUM_TIMERS periodic timers sharing one tick.
// Input channel (in_valid/in_ready) takes one request: action, timer_id and
// interval_sixteenths. Start, stop and tick give no answer; the two queries
// each give one flag on the result channel (out_valid/out_ready).
// Steps per request, from acceptance to the next request being taken:
//   tick, start, unused codes: handled in the idle state, no further step
//   stop:                      one read-modify-write of one entry (S_RMW)
//   query:                     a sweep over every entry (S_SWEEP), then the
//                              flag is registered from S_DONE.
// The query sweeps through the timer RAM: one entry is read and written
// back per cycle to apply the pending ticks.
// The answer sits in an output register, so requests continue while it
// waits. A stalled receiver only holds up a second query at its last step.
// Reset (rst_n, synchronous, active low) clears the pending count, the FSM,
// the output and one valid bit per entry; an entry never written reads as
// zero, so no clearing pass is needed and requests are taken straight away.
module periodic_timer_bank #(
  parameter int NUM_TIMERS  = ptb_pkg::NUM_TIMERS_DEF,
  parameter int PERIOD_BITS = ptb_pkg::PERIOD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ptb_pkg::ACT_W-1:0] in_action,
  input  logic [ptb_pkg::ID_W-1:0]  in_timer_id,
  input  logic [ptb_pkg::LEN_W-1:0] in_interval_sixteenths,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_flag
);
  import ptb_pkg::*;

  // Stored widths: intervals arrive as 24 bits, so nothing wider is kept.
  localparam int PW   = (PERIOD_BITS < LEN_W) ? PERIOD_BITS : LEN_W;
  localparam int EW   = 2 * PW + 2;
  localparam int IW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IW-1:0] LAST = IW'(NUM_TIMERS - 1);

  // Entry layout: {period, remaining, expired, running}
  localparam int RUN_B = 0;
  localparam int EXP_B = 1;
  localparam int REM_L = 2;
  localparam int PER_L = PW + 2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RMW   = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [PEND_W-1:0]     pend_r, pend_nxt;
  logic [IW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         rd_idx_r;
  logic [ACT_W-1:0]      act_r;
  logic [IW-1:0]         id_r;
  logic                  id_ok_r;
  logic                  hold_r, hold_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_flag_r, out_flag_nxt;
  logic [NUM_TIMERS-1:0] vld_r;

  // RAM port
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata, ent;

  // Incoming request decode
  logic          accept;
  logic [8:0]    id_ext;
  logic          id_ok;
  logic [IW-1:0] id_idx;
  logic [PW-1:0] len;

  // Sweep arithmetic on the entry just read
  logic [PW-1:0] per, rem, rem_new;
  logic          exp_new, run_cur, hit;

  assign accept = in_valid && in_ready;
  assign id_ext = 9'(in_timer_id);
  assign id_ok  = id_ext < 9'(NUM_TIMERS);
  assign id_idx = id_ext[IW-1:0];
  assign len    = (in_interval_sixteenths[PW-1:0] == '0) ? PW'(1)
                                                         : in_interval_sixteenths[PW-1:0];

  // Never-written entries read as zero
  assign ent = vld_r[rd_idx_r] ? ram_rdata : '0;

  assign per     = ent[PER_L +: PW];
  assign rem     = ent[REM_L +: PW];
  assign run_cur = ent[RUN_B];
  assign hit     = id_ok_r && (cnt_r == id_r);

  always_comb begin
    rem_new = rem;
    exp_new = ent[EXP_B];
    if (pend_r != '0 && per != '0) begin
      if (PEND_W'(rem) <= pend_r) begin
        rem_new = per;   // re-arm, overshoot dropped
        exp_new = 1'b1;
      end else begin
        rem_new = rem - pend_r[PW-1:0];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r;
    out_flag_nxt  = out_flag_r;
    ram_we        = 1'b0;
    ram_waddr     = id_idx;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = id_idx;
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          case (in_action)
            ACT_START: begin
              if (id_ok) begin
                ram_we    = 1'b1;
                ram_wdata = {len, len, 1'b0, 1'b1};
              end
            end
            ACT_STOP: begin
              if (id_ok) begin
                ram_re    = 1'b1;
                state_nxt = S_RMW;
              end
            end
            ACT_TICK: begin
              if (pend_r != '1) begin
                pend_nxt = pend_r + PEND_W'(1);
              end
            end
            ACT_QEXP, ACT_QRUN: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              cnt_nxt   = '0;
              hold_nxt  = 1'b0;
              state_nxt = S_SWEEP;
            end
            default: ;
          endcase
        end
      end
      S_RMW: begin
        // stop: period and running cleared, remaining and expired kept
        ram_we    = 1'b1;
        ram_waddr = id_r;
        ram_wdata = {PW'(0), rem, ent[EXP_B], 1'b0};
        state_nxt = S_IDLE;
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = {per, rem_new, exp_new, run_cur};
        if (hit) begin
          if (act_r == ACT_QEXP) begin
            hold_nxt  = exp_new;
            ram_wdata = {per, rem_new, 1'b0, run_cur};
          end else begin
            hold_nxt = run_cur;
          end
        end
        if (cnt_r == LAST) begin
          pend_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r + IW'(1);
          cnt_nxt   = cnt_r + IW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt  = hold_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Payload and request registers, no reset needed
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    hold_r     <= hold_nxt;
    out_flag_r <= out_flag_nxt;
    if (ram_re) begin
      rd_idx_r <= ram_raddr;
    end
    if (accept) begin
      act_r   <= in_action;
      id_r    <= id_idx;
      id_ok_r <= id_ok;
    end
  end

  ptb_ram #(
    .W     (EW),
    .DEPTH (NUM_TIMERS),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_flag  = out_flag_r;

`ifndef SYNTHESIS
  // Pending count only moves at the end of a sweep while one is running
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && cnt_r != LAST) |=> (pend_r == $past(pend_r)))
    else $error("pending count changed mid-sweep");

  a_pend_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && cnt_r == LAST) |=> (pend_r == '0))
    else $error("pending count not cleared after sweep");

  // Read-ahead never targets the entry being written back
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("answer raised outside the final step");
`endif

endmodule
